/* sv/epfs_pkg.sv */
// Shared constants, types and helper functions of the e-paper frame store refresh pacer.
package epfs_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH   = 200;
    localparam int FRAME_HEIGHT  = 200;
    localparam int BYTES_PER_ROW = (FRAME_WIDTH + 3) / 4;
    localparam int FRAME_BYTES   = BYTES_PER_ROW * FRAME_HEIGHT;
    localparam int ADDR_W        = $clog2(FRAME_BYTES);
    localparam int CNT_W         = $clog2(FRAME_BYTES + 1);

    // Coordinate checks use the low 11 bits of a non-negative 12-bit coordinate
    localparam logic [10:0] WIDTH_LIM  = 11'(FRAME_WIDTH);
    localparam logic [10:0] HEIGHT_LIM = 11'(FRAME_HEIGHT);

    // FNV-1a 32-bit
    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    // Reset values
    localparam logic [7:0]  WHITE_BYTE   = 8'h55;
    localparam logic [15:0] SETTLE_RESET = 16'd600;
    localparam logic [15:0] FLOOR_RESET  = 16'd4000;
    localparam logic [1:0]  RED_RESET    = 2'd3;
    localparam logic [1:0]  YELLOW_RESET = 2'd2;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_FILL  = 2'd1,
        OP_TICK  = 2'd2,
        OP_BEGIN = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SETTLE = 2'd0,
        CFG_FLOOR  = 2'd1,
        CFG_RED    = 2'd2,
        CFG_YELLOW = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX,
        ST_FILL,
        ST_HASH,
        ST_DONE
    } st_t;

    // One FNV-1a byte step
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return 32'(x * HASH_PRIME);
    endfunction

    // Replace one 2-bit pixel in a packed byte; pixel 0 sits in bits 7:6
    function automatic logic [7:0] pixel_merge(input logic [7:0] b, input logic [1:0] pos,
                                               input logic [1:0] code);
        logic [7:0] r;
        r = b;
        case (pos)
            2'd0:    r[7:6] = code;
            2'd1:    r[5:4] = code;
            2'd2:    r[3:2] = code;
            2'd3:    r[1:0] = code;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

/* sv/epfs_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module epfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/epaper_frame_store_refresh_pacer_core.sv */
// Top level: frame store in RAM, pixel/fill writer, FNV-1a hash walker and refresh pacer.
//
// The frame (200 x 200 pixels, 2 bits each, four pixels to a byte, 10000 bytes)
// lives in one single-port-write, registered-read RAM. After reset the block
// runs a clearing pass that writes white into every byte, one byte a cycle,
// with s_ready low; configuration writes are taken throughout.
// One item is worked on at a time. A pixel draw is a read-modify-write of one
// byte. A tick that does not need the hash skips the walk. A fill writes every
// byte through the RAM write port. A tick that hashes, and a begin, stream
// every byte through the read port into the FNV-1a unit at one byte a cycle.
// The result sits in an output register, so the next item is accepted while
// it waits to be taken.
module epaper_frame_store_refresh_pacer_core (
    input  logic               aclk,
    input  logic               aresetn,
    // item channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [11:0] s_pixel_x,
    input  logic signed [11:0] s_pixel_y,
    input  logic [1:0]         s_color_code,
    input  logic               s_is_orange,
    input  logic [31:0]        s_now_ms,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_refresh_start,
    output logic               m_hash_matched,
    output logic               m_pending,
    output logic [31:0]        m_frame_hash,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = epfs_pkg::ADDR_W;
    localparam int CW = epfs_pkg::CNT_W;

    // Control state
    epfs_pkg::st_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          m_valid_reg, m_valid_next;

    // Pacer state and configuration
    logic          pending_reg, pending_next;
    logic [31:0]   last_draw_reg, last_draw_next;
    logic [31:0]   last_refresh_reg, last_refresh_next;
    logic [31:0]   shown_hash_reg, shown_hash_next;
    logic [15:0]   settle_reg;
    logic [15:0]   floor_reg;
    logic [1:0]    red_reg;
    logic [1:0]    yellow_reg;

    // Latched item
    epfs_pkg::op_t req_op_reg, req_op_next;
    logic [1:0]    req_code_reg, req_code_next;
    logic [1:0]    req_pos_reg, req_pos_next;
    logic          req_hit_reg, req_hit_next;
    logic [AW-1:0] req_idx_reg, req_idx_next;
    logic [31:0]   req_now_reg, req_now_next;
    logic [31:0]   hash_reg, hash_next;

    // Output payload
    logic          out_start_reg, out_start_next;
    logic          out_match_reg, out_match_next;
    logic          out_pend_reg, out_pend_next;
    logic [31:0]   out_hash_reg, out_hash_next;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          s_fire;
    logic          out_free;
    logic          last_cnt;
    logic          in_hit;
    logic [AW-1:0] in_idx;
    logic          in_par;
    logic [1:0]    in_code;
    logic          in_tick_go;
    logic          req_tick_go;
    logic          req_floor_ok;
    epfs_pkg::op_t in_op;

    epfs_ram #(
        .WIDTH (8),
        .DEPTH (epfs_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes
    assign s_ready   = (state_reg == epfs_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_refresh_start = out_start_reg;
    assign m_hash_matched  = out_match_reg;
    assign m_pending       = out_pend_reg;
    assign m_frame_hash    = out_hash_reg;

    // Incoming item decode: clipping, byte address, dithered color
    assign in_op  = epfs_pkg::op_t'(s_opcode);
    assign in_hit = !s_pixel_x[11] && (s_pixel_x[10:0] < epfs_pkg::WIDTH_LIM)
                 && !s_pixel_y[11] && (s_pixel_y[10:0] < epfs_pkg::HEIGHT_LIM);
    assign in_idx = AW'(s_pixel_y[10:0] * epfs_pkg::BYTES_PER_ROW) + AW'(s_pixel_x[10:2]);
    assign in_par = s_pixel_x[0] ^ s_pixel_y[0];

    always_comb begin
        in_code = s_color_code;
        if (s_is_orange) begin
            if (in_op == epfs_pkg::OP_DRAW && in_par) begin
                in_code = red_reg;
            end else begin
                in_code = yellow_reg;
            end
        end
    end

    // Timer checks, modulo 2^32
    assign in_tick_go   = pending_reg && (32'(s_now_ms - last_draw_reg) >= {16'd0, settle_reg});
    assign req_tick_go  = pending_reg && (32'(req_now_reg - last_draw_reg) >= {16'd0, settle_reg});
    assign req_floor_ok = 32'(req_now_reg - last_refresh_reg) >= {16'd0, floor_reg};
    assign last_cnt     = (cnt_reg == CW'(epfs_pkg::FRAME_BYTES - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            epfs_pkg::ST_CLEAR: begin
                if (last_cnt) begin
                    state_next = epfs_pkg::ST_IDLE;
                end
            end
            epfs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (in_op)
                        epfs_pkg::OP_DRAW:  state_next = epfs_pkg::ST_PIX;
                        epfs_pkg::OP_FILL:  state_next = epfs_pkg::ST_FILL;
                        epfs_pkg::OP_TICK:  state_next = in_tick_go ? epfs_pkg::ST_HASH
                                                                    : epfs_pkg::ST_DONE;
                        epfs_pkg::OP_BEGIN: state_next = epfs_pkg::ST_HASH;
                        default:            state_next = epfs_pkg::ST_IDLE;
                    endcase
                end
            end
            epfs_pkg::ST_PIX: begin
                if (out_free) begin
                    state_next = epfs_pkg::ST_IDLE;
                end
            end
            epfs_pkg::ST_FILL: begin
                if (last_cnt) begin
                    state_next = epfs_pkg::ST_DONE;
                end
            end
            epfs_pkg::ST_HASH: begin
                if (cnt_reg == CW'(epfs_pkg::FRAME_BYTES) && rd_vld_reg) begin
                    state_next = epfs_pkg::ST_DONE;
                end
            end
            epfs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = epfs_pkg::ST_IDLE;
                end
            end
            default: state_next = epfs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb begin
        cnt_next          = cnt_reg;
        rd_vld_next       = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        pending_next      = pending_reg;
        last_draw_next    = last_draw_reg;
        last_refresh_next = last_refresh_reg;
        shown_hash_next   = shown_hash_reg;
        req_op_next       = req_op_reg;
        req_code_next     = req_code_reg;
        req_pos_next      = req_pos_reg;
        req_hit_next      = req_hit_reg;
        req_idx_next      = req_idx_reg;
        req_now_next      = req_now_reg;
        hash_next         = hash_reg;
        out_start_next    = out_start_reg;
        out_match_next    = out_match_reg;
        out_pend_next     = out_pend_reg;
        out_hash_next     = out_hash_reg;
        ram_we            = 1'b0;
        ram_waddr         = cnt_reg[AW-1:0];
        ram_wdata         = {4{req_code_reg}};
        ram_re            = 1'b0;
        ram_raddr         = in_idx;

        case (state_reg)
            // Reset clearing pass: white into every byte
            epfs_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = epfs_pkg::WHITE_BYTE;
                cnt_next  = last_cnt ? '0 : CW'(cnt_reg + 1'b1);
            end
            // Latch the item; a draw that hits the frame reads its byte right away
            epfs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    req_op_next   = in_op;
                    req_code_next = in_code;
                    req_pos_next  = s_pixel_x[1:0];
                    req_hit_next  = in_hit;
                    req_idx_next  = in_idx;
                    req_now_next  = s_now_ms;
                    hash_next     = epfs_pkg::HASH_BASIS;
                    cnt_next      = '0;
                    ram_re        = (in_op == epfs_pkg::OP_DRAW) && in_hit;
                end
            end
            // Pixel write-back and result
            epfs_pkg::ST_PIX: begin
                ram_waddr = req_idx_reg;
                ram_wdata = epfs_pkg::pixel_merge(ram_rdata, req_pos_reg, req_code_reg);
                if (out_free) begin
                    ram_we         = req_hit_reg;
                    pending_next   = 1'b1;
                    last_draw_next = req_now_reg;
                    m_valid_next   = 1'b1;
                    out_start_next = 1'b0;
                    out_match_next = 1'b0;
                    out_pend_next  = 1'b1;
                    out_hash_next  = '0;
                end
            end
            // Fill sweep
            epfs_pkg::ST_FILL: begin
                ram_we   = 1'b1;
                cnt_next = CW'(cnt_reg + 1'b1);
            end
            // Hash walk: issue one read a cycle, fold the byte read last cycle
            epfs_pkg::ST_HASH: begin
                ram_raddr = cnt_reg[AW-1:0];
                if (cnt_reg != CW'(epfs_pkg::FRAME_BYTES)) begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    cnt_next    = CW'(cnt_reg + 1'b1);
                end
                if (rd_vld_reg) begin
                    hash_next = epfs_pkg::fnv_step(hash_reg, ram_rdata);
                end
            end
            // Commit pacer state and hand over the result
            epfs_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_start_next = 1'b0;
                    out_match_next = 1'b0;
                    out_hash_next  = '0;
                    case (req_op_reg)
                        epfs_pkg::OP_FILL: begin
                            pending_next   = 1'b1;
                            last_draw_next = req_now_reg;
                            out_pend_next  = 1'b1;
                        end
                        epfs_pkg::OP_TICK: begin
                            out_pend_next = pending_reg;
                            if (req_tick_go) begin
                                out_hash_next = hash_reg;
                                if (hash_reg == shown_hash_reg) begin
                                    pending_next   = 1'b0;
                                    out_pend_next  = 1'b0;
                                    out_match_next = 1'b1;
                                end else if (req_floor_ok) begin
                                    pending_next      = 1'b0;
                                    out_pend_next     = 1'b0;
                                    out_start_next    = 1'b1;
                                    shown_hash_next   = hash_reg;
                                    last_refresh_next = req_now_reg;
                                end
                            end
                        end
                        epfs_pkg::OP_BEGIN: begin
                            out_start_next    = 1'b1;
                            out_pend_next     = pending_reg;
                            out_hash_next     = hash_reg;
                            shown_hash_next   = hash_reg;
                            last_refresh_next = req_now_reg;
                        end
                        default: begin
                            out_pend_next = pending_reg;
                        end
                    endcase
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control and pacer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= epfs_pkg::ST_CLEAR;
            cnt_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            last_draw_reg    <= '0;
            last_refresh_reg <= '0;
            shown_hash_reg   <= '0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            rd_vld_reg       <= rd_vld_next;
            m_valid_reg      <= m_valid_next;
            pending_reg      <= pending_next;
            last_draw_reg    <= last_draw_next;
            last_refresh_reg <= last_refresh_next;
            shown_hash_reg   <= shown_hash_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= epfs_pkg::SETTLE_RESET;
            floor_reg  <= epfs_pkg::FLOOR_RESET;
            red_reg    <= epfs_pkg::RED_RESET;
            yellow_reg <= epfs_pkg::YELLOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (epfs_pkg::cfg_idx_t'(cfg_index))
                epfs_pkg::CFG_SETTLE: settle_reg <= cfg_data;
                epfs_pkg::CFG_FLOOR:  floor_reg  <= cfg_data;
                epfs_pkg::CFG_RED:    red_reg    <= cfg_data[1:0];
                epfs_pkg::CFG_YELLOW: yellow_reg <= cfg_data[1:0];
                default:              settle_reg <= settle_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_op_reg    <= req_op_next;
        req_code_reg  <= req_code_next;
        req_pos_reg   <= req_pos_next;
        req_hit_reg   <= req_hit_next;
        req_idx_reg   <= req_idx_next;
        req_now_reg   <= req_now_next;
        hash_reg      <= hash_next;
        out_start_reg <= out_start_next;
        out_match_reg <= out_match_next;
        out_pend_reg  <= out_pend_next;
        out_hash_reg  <= out_hash_next;
    end

endmodule

/* tb/epaper_frame_store_refresh_pacer_core_tb.sv */
// Self-checking testbench for the e-paper frame store refresh pacer core.
module epaper_frame_store_refresh_pacer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        epfs_pkg::op_t      op;
        logic signed [11:0] px;
        logic signed [11:0] py;
        logic [1:0]         code;
        logic               orange;
        logic [31:0]        now;
    } pacer_cmd_t;

    typedef struct {
        logic        refresh_start;
        logic        hash_matched;
        logic        pending;
        logic [31:0] frame_hash;
    } pacer_result_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #5 aclk = ~aclk;

    // DUT ports
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode     = '0;
    logic signed [11:0] s_pixel_x    = '0;
    logic signed [11:0] s_pixel_y    = '0;
    logic [1:0]         s_color_code = '0;
    logic               s_is_orange  = 1'b0;
    logic [31:0]        s_now_ms     = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_refresh_start;
    logic               m_hash_matched;
    logic               m_pending;
    logic [31:0]        m_frame_hash;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index    = '0;
    logic [15:0]        cfg_data     = '0;

    epaper_frame_store_refresh_pacer_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel_x       (s_pixel_x),
        .s_pixel_y       (s_pixel_y),
        .s_color_code    (s_color_code),
        .s_is_orange     (s_is_orange),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_refresh_start (m_refresh_start),
        .m_hash_matched  (m_hash_matched),
        .m_pending       (m_pending),
        .m_frame_hash    (m_frame_hash),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Register shadows, updated on each accepted config beat
    logic [15:0] cfg_settle = epfs_pkg::SETTLE_RESET;
    logic [15:0] cfg_floor  = epfs_pkg::FLOOR_RESET;
    logic [1:0]  cfg_red    = epfs_pkg::RED_RESET;
    logic [1:0]  cfg_yellow = epfs_pkg::YELLOW_RESET;

    // Pacer state mirror
    logic [7:0]  frame_img [epfs_pkg::FRAME_BYTES];
    logic        mdl_pending      = 1'b0;
    logic [31:0] mdl_last_draw    = '0;
    logic [31:0] mdl_last_refresh = '0;
    logic [31:0] mdl_shown        = '0;

    pacer_cmd_t    pacer_cmds[$];
    pacer_result_t results_due[$];
    int            accepted_count  = 0;
    int            mismatch_count  = 0;

    // Stimulus generator bookkeeping
    int          gen_count     = 0;
    logic [31:0] t_ms          = '0;
    logic [31:0] gen_last_draw = '0;
    bit          fill_known    = 1'b0;
    logic [1:0]  fill_code     = '0;
    int          slow_left     = 0;

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int sink_hold_left = 0;

    // FNV-1a over the mirrored frame
    function automatic logic [31:0] frame_fnv1a();
        logic [31:0] h;
        h = epfs_pkg::HASH_BASIS;
        foreach (frame_img[i]) h = (h ^ {24'd0, frame_img[i]}) * epfs_pkg::HASH_PRIME;
        return h;
    endfunction

    // Advance the mirror by one command and return the result it yields
    function automatic pacer_result_t apply_pacer_cmd(pacer_cmd_t c);
        pacer_result_t r;
        int          x, y, idx, sh;
        logic [1:0]  code;
        logic [31:0] h;
        r = '{1'b0, 1'b0, 1'b0, 32'd0};
        x = int'(c.px);
        y = int'(c.py);
        code = c.code;
        case (c.op)
            epfs_pkg::OP_DRAW: begin
                if (x >= 0 && x < epfs_pkg::FRAME_WIDTH
                    && y >= 0 && y < epfs_pkg::FRAME_HEIGHT) begin
                    // checker dither: odd sum gets red, even sum yellow
                    if (c.orange) code = ((x + y) % 2 != 0) ? cfg_red : cfg_yellow;
                    idx = y * epfs_pkg::BYTES_PER_ROW + x / 4;
                    sh = 6 - 2 * (x % 4);
                    frame_img[idx][sh +: 2] = code;
                end
                mdl_pending = 1'b1;
                mdl_last_draw = c.now;
            end
            epfs_pkg::OP_FILL: begin
                code = c.orange ? cfg_yellow : c.code;
                foreach (frame_img[i]) frame_img[i] = {4{code}};
                mdl_pending = 1'b1;
                mdl_last_draw = c.now;
            end
            epfs_pkg::OP_TICK: begin
                if (mdl_pending && (32'(c.now - mdl_last_draw) >= {16'd0, cfg_settle})) begin
                    h = frame_fnv1a();
                    r.frame_hash = h;
                    if (h == mdl_shown) begin
                        mdl_pending = 1'b0;
                        r.hash_matched = 1'b1;
                    end else if (32'(c.now - mdl_last_refresh) >= {16'd0, cfg_floor}) begin
                        r.refresh_start = 1'b1;
                        mdl_shown = h;
                        mdl_last_refresh = c.now;
                        mdl_pending = 1'b0;
                    end
                end
            end
            default: begin
                h = frame_fnv1a();
                r.frame_hash = h;
                r.refresh_start = 1'b1;
                mdl_last_refresh = c.now;
                mdl_shown = h;
            end
        endcase
        r.pending = mdl_pending;
        return r;
    endfunction

    // Input side: one beat per queued command, random gap after each beat when tx_idle is set
    int tx_gap = 0;
    always @(posedge aclk) begin : cmd_source
        pacer_cmd_t cur_cmd;
        int         gap_n;
        bit         busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            gap_n = tx_gap;
            busy = s_valid;
            if (s_valid && s_ready) begin
                results_due.push_back(apply_pacer_cmd(cur_cmd));
                accepted_count++;
                gap_n = tx_idle ? int'($urandom_range(0, 9)) : 0;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_n != 0) begin
                    s_valid <= 1'b0;
                    gap_n--;
                end else if (pacer_cmds.size() != 0) begin
                    cur_cmd = pacer_cmds.pop_front();
                    s_opcode <= cur_cmd.op;
                    s_pixel_x <= cur_cmd.px;
                    s_pixel_y <= cur_cmd.py;
                    s_color_code <= cur_cmd.code;
                    s_is_orange <= cur_cmd.orange;
                    s_now_ms <= cur_cmd.now;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            tx_gap <= gap_n;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn) sink_hold_left <= 0;
        else if (hold_req) sink_hold_left <= 400;
        else if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: compare each beat with the oldest prediction
    int rx_gap = 0;
    always @(posedge aclk) begin : result_sink
        pacer_result_t want;
        int            gap_n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            gap_n = rx_gap;
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t ns: result beat with no prediction pending", $time);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("refresh_start", 32'(want.refresh_start), 32'(m_refresh_start));
                    check_field("hash_matched", 32'(want.hash_matched), 32'(m_hash_matched));
                    check_field("pending", 32'(want.pending), 32'(m_pending));
                    check_field("frame_hash", want.frame_hash, m_frame_hash);
                end
                gap_n = rx_idle ? int'($urandom_range(0, 9)) : 0;
            end
            if (sink_hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (gap_n != 0) begin
                m_ready <= 1'b0;
                gap_n--;
            end else begin
                m_ready <= 1'b1;
            end
            rx_gap <= gap_n;
        end
    end

    task automatic write_reg(input epfs_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            epfs_pkg::CFG_SETTLE: cfg_settle = val;
            epfs_pkg::CFG_FLOOR:  cfg_floor = val;
            epfs_pkg::CFG_RED:    cfg_red = val[1:0];
            default:              cfg_yellow = val[1:0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Wait until every command is accepted and every result checked
    task automatic drain();
        while (accepted_count != gen_count || results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_cmd(input epfs_pkg::op_t op, input int x, input int y,
                            input logic [1:0] code, input logic orange,
                            input logic [31:0] now);
        pacer_cmd_t c;
        c.op = op;
        c.px = x[11:0];
        c.py = y[11:0];
        c.code = code;
        c.orange = orange;
        c.now = now;
        pacer_cmds.push_back(c);
        gen_count++;
        if (op == epfs_pkg::OP_DRAW || op == epfs_pkg::OP_FILL) gen_last_draw = now;
        t_ms = now;
    endtask

    function automatic int rand12();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic push_frame_draw();
        push_cmd(epfs_pkg::OP_DRAW, $urandom_range(0, epfs_pkg::FRAME_WIDTH - 1),
                 $urandom_range(0, epfs_pkg::FRAME_HEIGHT - 1),
                 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                 t_ms + $urandom_range(0, 40));
        fill_known = 1'b0;
    endtask

    // Draw with at least one coordinate off the frame
    task automatic push_clipped_draw();
        int off_c;
        if ($urandom_range(0, 1)) begin
            off_c = $urandom_range(0, 1) ? int'($urandom_range(epfs_pkg::FRAME_WIDTH, 2047))
                                         : -int'($urandom_range(1, 2048));
            push_cmd(epfs_pkg::OP_DRAW, off_c, rand12(), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), t_ms + $urandom_range(0, 40));
        end else begin
            off_c = $urandom_range(0, 1) ? int'($urandom_range(epfs_pkg::FRAME_HEIGHT, 2047))
                                         : -int'($urandom_range(1, 2048));
            push_cmd(epfs_pkg::OP_DRAW, rand12(), off_c, 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), t_ms + $urandom_range(0, 40));
        end
    endtask

    // Tick inside the settle window (cheap: no hash walk)
    task automatic push_quiet_tick();
        push_cmd(epfs_pkg::OP_TICK, rand12(), rand12(), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), gen_last_draw + $urandom_range(0, cfg_settle - 1));
    endtask

    // Tick past the settle window; sometimes far enough to clear the floor
    task automatic push_settled_tick();
        logic [31:0] jump;
        jump = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 90000);
        push_cmd(epfs_pkg::OP_TICK, rand12(), rand12(), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), gen_last_draw + {16'd0, cfg_settle} + jump);
    endtask

    task automatic gen_sketch(input int n, input bit close_with_tick);
        int k, pick;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) push_frame_draw();
            else if (pick < 8 || cfg_settle == 0) push_clipped_draw();
            else push_quiet_tick();
        end
        if (close_with_tick) push_settled_tick();
    endtask

    // Mostly drawing bursts closed by a settled tick, plus fills, begins,
    // pixel touch-and-restore runs and fully random noise
    task automatic run_random_phase(input int n_items);
        int         phase_end, kind, k, px, py;
        logic [1:0] code;
        logic       orange;
        phase_end = gen_count + n_items;
        slow_left = 14;
        while (gen_count < phase_end) begin
            kind = $urandom_range(0, 99);
            if (slow_left == 0) begin
                gen_sketch($urandom_range(4, 20), 1'b0);
            end else if (kind < 10 && slow_left >= 2) begin
                code = 2'($urandom_range(0, 3));
                orange = 1'($urandom_range(0, 1));
                push_cmd(epfs_pkg::OP_FILL, rand12(), rand12(), code, orange,
                         t_ms + $urandom_range(0, 100));
                fill_code = orange ? cfg_yellow : code;
                fill_known = 1'b1;
                push_settled_tick();
                slow_left -= 2;
            end else if (kind < 16) begin
                push_cmd(epfs_pkg::OP_BEGIN, rand12(), rand12(), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), t_ms + $urandom_range(0, 5000));
                slow_left--;
            end else if (kind < 36 && fill_known) begin
                // scribble one pixel, put the fill color back: frame unchanged
                px = $urandom_range(0, epfs_pkg::FRAME_WIDTH - 1);
                py = $urandom_range(0, epfs_pkg::FRAME_HEIGHT - 1);
                repeat ($urandom_range(1, 4))
                    push_cmd(epfs_pkg::OP_DRAW, px, py, 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)), t_ms + $urandom_range(0, 40));
                if ($urandom_range(0, 1)) push_clipped_draw();
                push_cmd(epfs_pkg::OP_DRAW, px, py, fill_code, 1'b0,
                         t_ms + $urandom_range(0, 40));
                push_settled_tick();
                slow_left--;
            end else if (kind < 46 && slow_left >= 4) begin
                for (k = 0; k < int'($urandom_range(1, 4)); k++) begin
                    if ($urandom_range(0, 1)) begin
                        push_cmd(epfs_pkg::OP_TICK, rand12(), rand12(),
                                 2'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), $urandom());
                        slow_left--;
                    end else begin
                        push_cmd(epfs_pkg::OP_DRAW, rand12(), rand12(),
                                 2'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), $urandom());
                        fill_known = 1'b0;
                    end
                end
            end else begin
                gen_sketch($urandom_range(4, 30), 1'b1);
                slow_left--;
            end
        end
    endtask

    initial begin : main_seq
        int p;
        foreach (frame_img[i]) frame_img[i] = epfs_pkg::WHITE_BYTE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset register values, every op and timer case
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd5);          // idle tick
        push_cmd(epfs_pkg::OP_BEGIN, 0, 0, 2'd0, 1'b0, 32'd10);        // white baseline
        push_cmd(epfs_pkg::OP_DRAW, 0, 0, 2'd1, 1'b0, 32'd100);
        push_cmd(epfs_pkg::OP_DRAW, 199, 199, 2'd0, 1'b0, 32'd110);
        push_cmd(epfs_pkg::OP_DRAW, -1, 5, 2'd2, 1'b0, 32'd120);       // clipped
        push_cmd(epfs_pkg::OP_DRAW, 200, 0, 2'd3, 1'b0, 32'd130);
        push_cmd(epfs_pkg::OP_DRAW, 2047, -2048, 2'd3, 1'b1, 32'd140);
        push_cmd(epfs_pkg::OP_DRAW, -2048, 2047, 2'd1, 1'b1, 32'd150);
        push_cmd(epfs_pkg::OP_DRAW, 1, 0, 2'd0, 1'b1, 32'd160);        // orange, odd -> red
        push_cmd(epfs_pkg::OP_DRAW, 2, 0, 2'd0, 1'b1, 32'd170);        // orange, even -> yellow
        push_cmd(epfs_pkg::OP_DRAW, 3, 199, 2'd3, 1'b1, 32'd180);
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd779);        // one ms short of settling
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd780);        // settled, under the floor
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd4010);       // exactly on the floor
        push_cmd(epfs_pkg::OP_DRAW, 0, 0, 2'd1, 1'b0, 32'd4100);       // same color again
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd4700);       // unchanged frame
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'd4800);       // idle again
        push_cmd(epfs_pkg::OP_FILL, 0, 0, 2'd3, 1'b0, 32'd5000);
        push_cmd(epfs_pkg::OP_FILL, 0, 0, 2'd0, 1'b1, 32'd5100);       // orange fill -> yellow
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'hFFFF_FF00);
        push_cmd(epfs_pkg::OP_DRAW, 5, 5, 2'd1, 1'b0, 32'h0000_0100);  // time wrapped
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'h0000_0358);  // floor across the wrap
        push_cmd(epfs_pkg::OP_BEGIN, 0, 0, 2'd0, 1'b0, 32'h0000_0400); // begin keeps pending
        push_cmd(epfs_pkg::OP_TICK, 0, 0, 2'd0, 1'b0, 32'h0000_0464);  // matches begin's hash
        drain();

        // Random phases, each with its own register setting
        for (p = 1; p <= 4; p++) begin
            case (p)
                1: begin
                    write_reg(epfs_pkg::CFG_SETTLE, 16'd600);
                    write_reg(epfs_pkg::CFG_FLOOR, 16'd4000);
                    write_reg(epfs_pkg::CFG_RED, {14'($urandom()), 2'd3});
                    write_reg(epfs_pkg::CFG_YELLOW, {14'($urandom()), 2'd2});
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                    t_ms = $urandom();
                end
                2: begin
                    write_reg(epfs_pkg::CFG_SETTLE, 16'd0);
                    write_reg(epfs_pkg::CFG_FLOOR, 16'd0);
                    write_reg(epfs_pkg::CFG_RED, {14'($urandom()), 2'd0});
                    write_reg(epfs_pkg::CFG_YELLOW, {14'($urandom()), 2'd1});
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                    t_ms = $urandom();
                end
                3: begin
                    write_reg(epfs_pkg::CFG_SETTLE, 16'hFFFF);
                    write_reg(epfs_pkg::CFG_FLOOR, 16'hFFFF);
                    write_reg(epfs_pkg::CFG_RED, {14'($urandom()), 2'd1});
                    write_reg(epfs_pkg::CFG_YELLOW, {14'($urandom()), 2'd3});
                    tx_idle = 1'b1;
                    rx_idle = 1'b0;
                    t_ms = 32'hFFFF_0000;
                end
                default: begin
                    write_reg(epfs_pkg::CFG_SETTLE, 16'($urandom_range(0, 3000)));
                    write_reg(epfs_pkg::CFG_FLOOR, 16'($urandom_range(0, 20000)));
                    write_reg(epfs_pkg::CFG_RED, 16'($urandom()));
                    write_reg(epfs_pkg::CFG_YELLOW, 16'($urandom()));
                    tx_idle = 1'b0;
                    rx_idle = 1'b1;
                    t_ms = $urandom();
                end
            endcase
            if (p == 2) begin
                // back-to-back draws against a held-off sink to fill the pipe
                repeat (6) push_frame_draw();
                @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            run_random_phase(240);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_due.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit: well beyond the slowest legal run (hash walks dominate)
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* epaper_frame_store_refresh_pacer_core.f */
sv/epfs_pkg.sv
sv/epfs_ram.sv
sv/epaper_frame_store_refresh_pacer_core.sv
tb/epaper_frame_store_refresh_pacer_core_tb.sv
